// ----- hdl/gjmi_pkg.sv -----
// ----------------------------------------------------------------------------
// gjmi_pkg
// Shared types, sizes and Q16.16 helpers for the Gauss-Jordan inverter.
// ----------------------------------------------------------------------------
package gjmi_pkg;

    localparam int MAX_ORDER = 4;
    localparam int CELLS     = MAX_ORDER * MAX_ORDER;
    localparam int ORD_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int N_W       = $clog2(MAX_ORDER + 1);
    localparam int TOT_W     = $clog2(CELLS + 1);

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic CFG_MATRIX_SIZE     = 1'b0;
    localparam logic CFG_PIVOT_THRESHOLD = 1'b1;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        logic shift;
        q_t   ins;
    } ring_ctl_t;

    function automatic q_t sat64(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // product / 65536, truncated toward zero, saturated
    function automatic q_t qscale(input logic signed [63:0] prod);
        logic signed [63:0] adj;
        logic signed [63:0] sh;
        adj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
        sh  = adj >>> 16;
        return sat64(sh);
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic signed [32:0] d;
        q_t r;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
            r = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = d[31:0];
        return r;
    endfunction

endpackage

// ----- hdl/gjmi_cell.sv -----
// ----------------------------------------------------------------------------
// gjmi_cell
// One storage cell of the matrix ring; passes its word to the neighbor.
// ----------------------------------------------------------------------------
module gjmi_cell
    import gjmi_pkg::*;
(
    input  logic      clk,
    input  ring_ctl_t ctl,
    input  logic      is_tail,
    input  q_t        next_data,
    output q_t        data
);

    q_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= is_tail ? ctl.ins : next_data;
        end
    end

    assign data = data_reg;

endmodule

// ----- hdl/gjmi_recip.sv -----
// ----------------------------------------------------------------------------
// gjmi_recip
// Bit-serial reciprocal: 2^32 / pivot, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module gjmi_recip
    import gjmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] mag,
    input  logic        neg,
    output logic        done,
    output q_t          quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [32:0] quo_reg;
    logic [31:0] div_reg;
    logic        neg_reg;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {rem_reg[31:0], (cnt_reg == 6'd32)};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            div_reg <= mag;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, div_reg}) : shifted;
            quo_reg <= {quo_reg[31:0], fits};
        end
    end

    always_comb
    begin
        if (!neg_reg)
            quot = (quo_reg > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_reg[31:0];
        else
            quot = (quo_reg >= 33'h0_8000_0000) ? 32'sh8000_0000 : -quo_reg[31:0];
    end

    assign done = done_reg;

endmodule

// ----- hdl/gauss_jordan_matrix_inverse_unit.sv -----
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_unit
// In-place Gauss-Jordan inversion of an n-by-n Q16.16 matrix, no pivoting.
// ----------------------------------------------------------------------------
// Elements load one per cycle into a ring of cells. Once the last element of a
// matrix is in, each pivot takes a scan pass, a check, a bit-serial reciprocal,
// a row-scale pass and an elimination pass; a pivot that fails the check ends
// the work instead. The scale and elimination passes wait on the registered
// multiply-saturate path (prod_reg, then q_reg) per touched element. The n*n
// results then leave one per cycle as the output side takes them, and no element
// is accepted until the last result has been issued.
module gauss_jordan_matrix_inverse_unit
    import gjmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  q_t          element,
    output logic        out_valid,
    input  logic        out_ready,
    output q_t          result_element,
    output logic        last,
    output logic        singular,
    output logic [2:0]  negative_pivots
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_ELIM  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       size_reg;
    logic [15:0]      thr_reg;
    logic [TOT_W-1:0] load_cnt_reg;
    logic [ORD_W-1:0] row_reg, col_reg, piv_reg;
    logic [1:0]       sub_reg;
    logic             sing_reg;
    logic [2:0]       negs_reg;
    q_t               p_reg, r_reg, q_reg;
    logic signed [63:0] prod_reg;
    q_t               fcol_reg [MAX_ORDER];
    q_t               prow_reg [MAX_ORDER];

    logic             out_valid_reg, out_last_reg;
    q_t               out_data_reg;
    logic             out_sing_reg;
    logic [2:0]       out_negs_reg;

    logic [N_W-1:0]   n_eff;
    logic [ORD_W-1:0] n_m1;
    logic [TOT_W-1:0] total_m1;
    ring_ctl_t        ctl;
    logic             advance;
    logic             end_pass;
    logic             out_free;
    logic             bad_pivot;
    logic             size_write;
    logic [31:0]      p_mag;
    q_t               mul_a, mul_b;
    q_t               head;
    q_t               cell_data [CELLS];
    logic             div_done;
    q_t               div_quot;

    always_comb
    begin
        if (size_reg == 3'd0)
            n_eff = N_W'(1);
        else if (int'(size_reg) > MAX_ORDER)
            n_eff = N_W'(MAX_ORDER);
        else
            n_eff = N_W'(size_reg);
    end

    assign n_m1       = ORD_W'(n_eff - N_W'(1));
    assign total_m1   = TOT_W'(int'(n_eff) * int'(n_eff) - 1);
    assign head       = cell_data[0];
    assign out_free   = !out_valid_reg || out_ready;
    assign end_pass   = (row_reg == n_m1) && (col_reg == n_m1);
    assign in_ready   = (state_reg == S_LOAD);
    assign size_write = cfg_write && (cfg_index == CFG_MATRIX_SIZE);

    assign p_mag     = p_reg[31] ? (~p_reg + 32'd1) : p_reg;
    assign bad_pivot = (p_reg == '0) || (p_mag <= {16'd0, thr_reg});

    always_comb
    begin
        ctl.shift = 1'b0;
        ctl.ins   = head;
        advance   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                ctl.shift = in_valid;
                ctl.ins   = element;
            end
            S_SCAN:
            begin
                ctl.shift = 1'b1;
                advance   = 1'b1;
            end
            S_SCALE:
            begin
                if (row_reg != piv_reg || sub_reg == 2'd2)
                begin
                    ctl.shift = 1'b1;
                    advance   = 1'b1;
                end
                if (row_reg == piv_reg)
                    ctl.ins = q_reg;
            end
            S_ELIM:
            begin
                if (row_reg == piv_reg || sub_reg == 2'd2)
                begin
                    ctl.shift = 1'b1;
                    advance   = 1'b1;
                end
                if (row_reg != piv_reg)
                    ctl.ins = sat_sub((col_reg == piv_reg) ? q_t'(0) : head, q_reg);
            end
            S_OUT:
            begin
                ctl.shift = out_free;
                advance   = out_free;
            end
            default:
            begin
                ctl.shift = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_SCALE)
        begin
            mul_a = (col_reg == piv_reg) ? Q_ONE : head;
            mul_b = r_reg;
        end
        else
        begin
            mul_a = fcol_reg[row_reg];
            mul_b = prow_reg[col_reg];
        end
    end

    genvar c;
    generate
        for (c = 0; c < CELLS; c++)
        begin : g_ring
            q_t nxt;
            if (c == CELLS - 1)
            begin : g_end
                assign nxt = ctl.ins;
            end
            else
            begin : g_mid
                assign nxt = cell_data[c + 1];
            end
            gjmi_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .is_tail   (total_m1 == TOT_W'(c)),
                .next_data (nxt),
                .data      (cell_data[c])
            );
        end
    endgenerate

    gjmi_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_CHK && !bad_pivot),
        .mag   (p_mag),
        .neg   (p_reg[31]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            size_reg      <= 3'd4;
            thr_reg       <= '0;
            load_cnt_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            piv_reg       <= '0;
            sub_reg       <= '0;
            sing_reg      <= 1'b0;
            negs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MATRIX_SIZE:
                    begin
                        size_reg <= cfg_data[2:0];
                    end
                    CFG_PIVOT_THRESHOLD:
                    begin
                        thr_reg <= cfg_data;
                    end
                    default:
                    begin
                        thr_reg <= thr_reg;
                    end
                endcase
            end

            if (advance)
            begin
                if (col_reg == n_m1)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == n_m1) ? '0 : row_reg + ORD_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + ORD_W'(1);
                end
            end

            if ((state_reg == S_SCALE && row_reg == piv_reg) ||
                (state_reg == S_ELIM && row_reg != piv_reg))
                sub_reg <= (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;

            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_LOAD:
                begin
                    if (size_write)
                    begin
                        load_cnt_reg <= '0;
                    end
                    else if (in_valid)
                    begin
                        if (load_cnt_reg == total_m1)
                        begin
                            load_cnt_reg <= '0;
                            state_reg    <= S_SCAN;
                            row_reg      <= '0;
                            col_reg      <= '0;
                            piv_reg      <= '0;
                            sing_reg     <= 1'b0;
                            negs_reg     <= '0;
                        end
                        else
                        begin
                            load_cnt_reg <= load_cnt_reg + TOT_W'(1);
                        end
                    end
                end
                S_SCAN:
                begin
                    if (end_pass)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (bad_pivot)
                    begin
                        sing_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (p_reg[31] && negs_reg != 3'd7)
                            negs_reg <= negs_reg + 3'd1;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SCALE;
                        sub_reg   <= '0;
                    end
                end
                S_SCALE:
                begin
                    if (advance && end_pass)
                        state_reg <= S_ELIM;
                end
                S_ELIM:
                begin
                    if (advance && end_pass)
                    begin
                        if (piv_reg == n_m1)
                            state_reg <= S_OUT;
                        else
                        begin
                            piv_reg   <= piv_reg + ORD_W'(1);
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free && end_pass)
                        state_reg <= S_LOAD;
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        q_reg    <= qscale(prod_reg);
        if (state_reg == S_SCAN && col_reg == piv_reg)
        begin
            fcol_reg[row_reg] <= head;
            if (row_reg == piv_reg)
                p_reg <= head;
        end
        if (state_reg == S_DIV && div_done)
            r_reg <= div_quot;
        if (state_reg == S_SCALE && row_reg == piv_reg && sub_reg == 2'd2)
            prow_reg[col_reg] <= q_reg;
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= head;
            out_last_reg <= end_pass;
            out_sing_reg <= sing_reg;
            out_negs_reg <= negs_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_element  = out_data_reg;
    assign last            = out_last_reg;
    assign singular        = out_sing_reg;
    assign negative_pivots = out_negs_reg;

endmodule

// ----- bench/gauss_jordan_matrix_inverse_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_unit_test
// Self-checking bench: matrices go in one element per beat. A Q16.16
// Gauss-Jordan predictor builds the expected inverse, and every result beat
// is checked against it. Order and threshold settings change between phases.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_unit_test;
    import gjmi_pkg::*;

    typedef struct {
        q_t         value;
        logic       is_last;
        logic       is_singular;
        logic [2:0] neg_count;
    } inverse_beat_t;

    localparam int IDLE_WAIT  = 40;
    localparam int STALL_MAX  = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_MATRIX_SIZE;
    logic [15:0] cfg_data = '0;
    logic        in_valid;
    logic        in_ready;
    q_t          element;
    logic        out_valid;
    logic        out_ready;
    q_t          result_element;
    logic        last;
    logic        singular;
    logic [2:0]  negative_pivots;

    q_t            element_queue[$];
    inverse_beat_t inverse_queue[$];

    // predictor state
    q_t       cell_store[CELLS];
    int       cells_loaded = 0;
    int       order_reg = 4;
    int       thresh_reg = 0;

    int       burst_max = 1;
    int       gap_max = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int       stall_pos = 0;

    int       errors = 0;
    int       elements_sent = 0;
    int       beats_checked = 0;
    int       matrices_done = 0;
    int       singular_seen = 0;
    int       idle_cycles = 0;

    gauss_jordan_matrix_inverse_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .element         (element),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_element  (result_element),
        .last            (last),
        .singular        (singular),
        .negative_pivots (negative_pivots)
    );

    always #5 clk = ~clk;

    function automatic q_t clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return q_t'(v);
    endfunction

    function automatic q_t fx_mul(input q_t a, input q_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clip32(prod / 65536);
    endfunction

    function automatic int order_eff();
        if (order_reg < 1)
            return 1;
        if (order_reg > MAX_ORDER)
            return MAX_ORDER;
        return order_reg;
    endfunction

    task automatic invert_and_expect(input int n);
        logic          stop;
        logic [2:0]    negs;
        q_t            piv;
        q_t            recip;
        q_t            f;
        longint        mag;
        inverse_beat_t beat;
        stop = 1'b0;
        negs = 3'd0;
        for (int i = 0; i < n && !stop; i++)
        begin
            piv = cell_store[i*n+i];
            mag = (piv < 0) ? -longint'(piv) : longint'(piv);
            if (mag <= longint'(thresh_reg) || piv == 0)
                stop = 1'b1;
            else
            begin
                if (piv < 0 && negs < 3'd7)
                    negs++;
                recip = clip32((64'sd1 <<< 32) / longint'(piv));
                cell_store[i*n+i] = Q_ONE;
                for (int k = 0; k < n; k++)
                    cell_store[i*n+k] = fx_mul(cell_store[i*n+k], recip);
                for (int j = 0; j < n; j++)
                begin
                    if (j != i)
                    begin
                        f = cell_store[j*n+i];
                        cell_store[j*n+i] = 0;
                        for (int k = 0; k < n; k++)
                            cell_store[j*n+k] = clip32(longint'(cell_store[j*n+k])
                                - longint'(fx_mul(f, cell_store[i*n+k])));
                    end
                end
            end
        end
        for (int k = 0; k < n*n; k++)
        begin
            beat.value       = cell_store[k];
            beat.is_last     = (k == n*n-1);
            beat.is_singular = stop;
            beat.neg_count   = negs;
            inverse_queue.push_back(beat);
        end
        matrices_done++;
        if (stop)
            singular_seen++;
    endtask

    task automatic load_element(input q_t v);
        int n;
        n = order_eff();
        if (cells_loaded >= n*n)
            cells_loaded = 0;
        cell_store[cells_loaded] = v;
        cells_loaded++;
        if (cells_loaded == n*n)
        begin
            invert_and_expect(n);
            cells_loaded = 0;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            element  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                load_element(element);
                elements_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (element_queue.size() > 0)
                begin
                    element  <= element_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(burst_max, 0);
                        gap_left   = $urandom_range(gap_max, 0);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        inverse_beat_t exp_beat;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (inverse_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat %h", $realtime, result_element);
                end
                else
                begin
                    exp_beat = inverse_queue.pop_front();
                    beats_checked++;
                    if (result_element !== exp_beat.value)
                    begin
                        errors++;
                        $display("%0t: result_element expected %h actual %h",
                                 $realtime, exp_beat.value, result_element);
                    end
                    if (last !== exp_beat.is_last)
                    begin
                        errors++;
                        $display("%0t: last expected %b actual %b",
                                 $realtime, exp_beat.is_last, last);
                    end
                    if (singular !== exp_beat.is_singular)
                    begin
                        errors++;
                        $display("%0t: singular expected %b actual %b",
                                 $realtime, exp_beat.is_singular, singular);
                    end
                    if (negative_pivots !== exp_beat.neg_count)
                    begin
                        errors++;
                        $display("%0t: negative_pivots expected %0d actual %0d",
                                 $realtime, exp_beat.neg_count, negative_pivots);
                    end
                end
            end
            out_ready <= stall_pattern[stall_pos];
            stall_pos = (stall_pos + 1) % 16;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_MAX)
            begin
                $display("gauss_jordan_matrix_inverse_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_MATRIX_SIZE)
        begin
            order_reg    = data[2:0];
            cells_loaded = 0;
        end
        else
            thresh_reg = data;
    endtask

    task automatic drain();
        while (element_queue.size() > 0 || in_valid || inverse_queue.size() > 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic set_traffic();
        if ($urandom_range(3, 0) == 0)
        begin
            gap_max       = 0;
            stall_pattern = 16'hFFFF;
        end
        else
        begin
            burst_max     = $urandom_range(12, 0);
            gap_max       = $urandom_range(9, 1);
            stall_pattern = 16'($urandom()) | 16'h0001;
        end
    endtask

    function automatic q_t rand_elem(input int n, input int r, input int c, input int style);
        q_t v;
        case (style)
            0: v = $urandom();
            1: v = $urandom_range(262143, 0) - 131072;
            2:
            begin
                if (r == c)
                    v = ($urandom_range(1, 0) ? 1 : -1) * $urandom_range(327680, 65536);
                else
                    v = $urandom_range(16383, 0) - 8192;
            end
            default:
                v = (r == c && r == $urandom_range(n-1, 0)) ? 0 : $urandom_range(200000, 0);
        endcase
        return v;
    endfunction

    initial
    begin
        int n;
        int style;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // order one: zero pivot, reciprocal overflow, extremes, negative pivot
        write_reg(CFG_MATRIX_SIZE, 16'd1);
        write_reg(CFG_PIVOT_THRESHOLD, 16'd0);
        element_queue = '{32'sh0, 32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh10000};
        drain();
        // order zero counts as one; pivot exactly at the threshold
        write_reg(CFG_MATRIX_SIZE, 16'd0);
        write_reg(CFG_PIVOT_THRESHOLD, 16'hFFFF);
        element_queue = '{32'sh0000_FFFF, 32'sh0001_0000, -32'sh0001_0001};
        drain();
        // order above the maximum; all pivots negative
        write_reg(CFG_MATRIX_SIZE, 16'd7);
        write_reg(CFG_PIVOT_THRESHOLD, 16'd0);
        for (int k = 0; k < 16; k++)
            element_queue.push_back((k % 5 == 0) ? -32'sh20000 : 32'sh0);
        drain();
        // partial matrix discarded by an order write
        write_reg(CFG_MATRIX_SIZE, 16'd3);
        element_queue = '{32'sh10000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5};
        drain();

        while (elements_sent < 370)
        begin
            write_reg(CFG_MATRIX_SIZE, ($urandom_range(7, 0) == 0) ?
                      16'($urandom_range(7, 0)) : 16'($urandom_range(4, 1)));
            case ($urandom_range(3, 0))
                0: write_reg(CFG_PIVOT_THRESHOLD, 16'd0);
                1: write_reg(CFG_PIVOT_THRESHOLD, 16'hFFFF);
                default: write_reg(CFG_PIVOT_THRESHOLD, 16'($urandom_range(4096, 0)));
            endcase
            set_traffic();
            n = order_eff();
            repeat ($urandom_range(6, 2))
            begin
                style = ($urandom_range(9, 0) < 6) ? 2 : $urandom_range(3, 0);
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        element_queue.push_back(rand_elem(n, r, c, style));
            end
            if ($urandom_range(4, 0) == 0)
                repeat ($urandom_range(n*n-1, 0))
                    element_queue.push_back($urandom());
            drain();
        end

        $display("Sent %0d elements, checked %0d result beats over %0d matrices",
                 elements_sent, beats_checked, matrices_done);
        $display("%0d matrices stopped at a small pivot", singular_seen);
        if (errors == 0)
            $display("gauss_jordan_matrix_inverse_unit regression: pass");
        else
            $display("gauss_jordan_matrix_inverse_unit regression: fail");
        $finish;
    end

endmodule
